FILE: design/bssp_pkg.sv
// Shared types, constants and helpers for the byte size string parser.
`default_nettype none
package bssp_pkg;

   localparam int unsigned CountWidth = 64;
   localparam int unsigned MatchWidth = 3;

   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [CountWidth-1:0] byte_size;
      logic                  status;
   } rsp_type;

   typedef enum logic [1:0] {
      PHASE_DIGITS  = 2'd0,
      PHASE_SUFFIX  = 2'd1,
      PHASE_INVALID = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      SUFFIX_NONE = 2'd0,
      SUFFIX_K    = 2'd1,
      SUFFIX_M    = 2'd2,
      SUFFIX_G    = 2'd3
   } suffix_type;

   localparam logic [MatchWidth-1:0] MatchFull   = 3'd3;
   localparam logic [MatchWidth-1:0] MatchBroken = 3'd7;

   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpZ   = 8'h5a;
   localparam logic [7:0] CaseDelta = 8'h20;
   localparam logic [7:0] CharLowK  = 8'h6b;
   localparam logic [7:0] CharLowM  = 8'h6d;
   localparam logic [7:0] CharLowG  = 8'h67;

   localparam logic [CountWidth-1:0] AllOnes = '1;

   // Steering signals from the top level into the parse core.
   typedef struct packed {
      logic    step;
      req_type item;
   } core_ctl_type;

   function automatic logic [7:0] lower_byte(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CharUpA && c <= CharUpZ) begin
         r = c + CaseDelta;
      end
      return r;
   endfunction

   // Characters of the word "max", by position.
   function automatic logic [7:0] max_char(input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = 8'h6d;
         2'd1:    r = 8'h61;
         2'd2:    r = 8'h78;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: design/bssp_parse_core.sv
// Parse state and per-character update for the byte size string parser.
`default_nettype none
module bssp_parse_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bssp_pkg::core_ctl_type ctl,
   output      bssp_pkg::rsp_type      result
);
   import bssp_pkg::*;

   logic [CountWidth-1:0] acc_ff,    acc_in;
   logic                  seen_ff,   seen_in;
   phase_type             phase_ff,  phase_in;
   suffix_type            suffix_ff, suffix_in;
   logic [MatchWidth-1:0] match_ff,  match_in;

   logic [7:0]            lc;
   logic                  is_digit;
   logic [3:0]            digit;
   logic [CountWidth+3:0] scaled;
   logic                  digit_ovf;

   assign lc       = lower_byte(ctl.item.character);
   assign is_digit = (ctl.item.character >= CharZero) && (ctl.item.character <= CharNine);
   assign digit    = ctl.item.character[3:0];
   assign scaled   = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                   + {{CountWidth{1'b0}}, digit};
   assign digit_ovf = |scaled[CountWidth+3:CountWidth];

   // Next state for one character.
   always_comb begin
      acc_in    = acc_ff;
      seen_in   = seen_ff;
      phase_in  = phase_ff;
      suffix_in = suffix_ff;

      if (match_ff < MatchFull && lc == max_char(match_ff[1:0])) begin
         match_in = match_ff + 3'd1;
      end else begin
         match_in = MatchBroken;
      end

      case (phase_ff)
         PHASE_DIGITS: begin
            if (is_digit) begin
               if (digit_ovf) begin
                  phase_in = PHASE_INVALID;
               end else begin
                  acc_in  = scaled[CountWidth-1:0];
                  seen_in = 1'b1;
               end
            end else if (!seen_ff) begin
               phase_in = PHASE_INVALID;
            end else if (lc == CharLowK) begin
               suffix_in = SUFFIX_K;
               phase_in  = PHASE_SUFFIX;
            end else if (lc == CharLowM) begin
               suffix_in = SUFFIX_M;
               phase_in  = PHASE_SUFFIX;
            end else if (lc == CharLowG) begin
               suffix_in = SUFFIX_G;
               phase_in  = PHASE_SUFFIX;
            end else begin
               phase_in = PHASE_INVALID;
            end
         end
         default: phase_in = PHASE_INVALID;
      endcase
   end

   // Result from the updated state.
   always_comb begin
      logic              fits;
      logic [CountWidth-1:0] shifted;
      case (suffix_in)
         SUFFIX_NONE: begin
            fits    = 1'b1;
            shifted = acc_in;
         end
         SUFFIX_K: begin
            fits    = ~|acc_in[CountWidth-1:CountWidth-10];
            shifted = acc_in << 10;
         end
         SUFFIX_M: begin
            fits    = ~|acc_in[CountWidth-1:CountWidth-20];
            shifted = acc_in << 20;
         end
         default: begin
            fits    = ~|acc_in[CountWidth-1:CountWidth-30];
            shifted = acc_in << 30;
         end
      endcase

      result.byte_size = '0;
      result.status    = 1'b1;
      if (match_in == MatchFull) begin
         result.byte_size = AllOnes;
         result.status    = 1'b0;
      end else if (phase_in != PHASE_INVALID && seen_in && fits) begin
         result.byte_size = shifted;
         result.status    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         seen_ff   <= 1'b0;
         phase_ff  <= PHASE_DIGITS;
         suffix_ff <= SUFFIX_NONE;
         match_ff  <= '0;
      end else if (ctl.step) begin
         if (ctl.item.last_char) begin
            // Drop everything at the end of a string.
            acc_ff    <= '0;
            seen_ff   <= 1'b0;
            phase_ff  <= PHASE_DIGITS;
            suffix_ff <= SUFFIX_NONE;
            match_ff  <= '0;
         end else begin
            acc_ff    <= acc_in;
            seen_ff   <= seen_in;
            phase_ff  <= phase_in;
            suffix_ff <= suffix_in;
            match_ff  <= match_in;
         end
      end
   end

endmodule
`default_nettype wire

FILE: design/byte_size_string_parser.sv
// Top level of the byte size string parser: input stage, parse core, result stage.
//
//   channel | direction | payload
//   req_    | in        | character, last_char  (bssp_pkg::req_type)
//   rsp_    | out       | byte_size, status     (bssp_pkg::rsp_type)
//
// One character per cycle while not stalled; results are registered in the result stage.
// The multiply-by-ten update of the parse state is combinational shifts and an add.
// Synchronous active-high reset clears both stages and the parse state.
// A stalled result holds; characters keep flowing until a final character meets a full result stage.
`default_nettype none
module byte_size_string_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire bssp_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      bssp_pkg::rsp_type rsp_data
);
   import bssp_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_type      in_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff;
   logic         out_free;
   logic         step;
   logic         load_rsp;
   core_ctl_type ctl;
   rsp_type      result;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // Advance the held character unless it is final and the result stage is full.
   assign step      = in_valid_ff && (!in_data_ff.last_char || out_free);
   assign load_rsp  = step && in_data_ff.last_char;
   assign req_ready = !in_valid_ff || step;

   assign ctl.step = step;
   assign ctl.item = in_data_ff;

   bssp_parse_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (load_rsp) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.byte_size == '0)
      else $error("invalid result carries a non-zero size");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && in_data_ff.last_char && !out_free)
      else $error("input stalled without a blocked final character");

   a_no_result_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_result_follows_final: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid)
      else $error("final character did not produce a result");

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the byte size string parser.
`default_nettype none
module tb;
   import bssp_pkg::*;

   localparam int unsigned ItemTarget = 2000;
   localparam int unsigned SteadyItems = 300;
   localparam logic [23:0] MaxWord = "max";
   localparam logic [7:0] CaseBit = 8'h20;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   byte_size_string_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Parser state as seen from outside
   logic [63:0] acc_count = '0;
   bit          digit_seen = 1'b0;
   phase_type   phase = PHASE_DIGITS;
   suffix_type  suffix = SUFFIX_NONE;
   logic [2:0]  max_matched = '0;

   rsp_type     expected_sizes[$];
   logic [7:0]  text_buf[$];
   int unsigned chars_sent = 0;
   int unsigned errors = 0;
   int          hold_left = 0;
   bit          steady = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 400000);
      $display("TB_ERROR");
      $finish;
   end

   function automatic void predict_parse(input logic [7:0] ch, input logic last);
      logic [7:0]  lc;
      logic [63:0] d;
      int unsigned shift;
      rsp_type     res;
      lc = (ch >= "A" && ch <= "Z") ? ch + CaseBit : ch;
      if (max_matched < MatchFull && lc == MaxWord[8 * (2 - max_matched) +: 8]) begin
         max_matched = max_matched + 3'd1;
      end else begin
         max_matched = MatchBroken;
      end
      if (phase == PHASE_DIGITS) begin
         if (ch >= "0" && ch <= "9") begin
            d = 64'(ch - "0");
            if (acc_count > (AllOnes - d) / 10) begin
               phase = PHASE_INVALID;
            end else begin
               acc_count = acc_count * 10 + d;
               digit_seen = 1'b1;
            end
         end else if (!digit_seen) begin
            phase = PHASE_INVALID;
         end else if (lc == "k") begin
            suffix = SUFFIX_K;
            phase = PHASE_SUFFIX;
         end else if (lc == "m") begin
            suffix = SUFFIX_M;
            phase = PHASE_SUFFIX;
         end else if (lc == "g") begin
            suffix = SUFFIX_G;
            phase = PHASE_SUFFIX;
         end else begin
            phase = PHASE_INVALID;
         end
      end else begin
         phase = PHASE_INVALID;
      end
      if (!last) return;
      res.byte_size = '0;
      res.status = 1'b1;
      if (max_matched == MatchFull) begin
         res.byte_size = AllOnes;
         res.status = 1'b0;
      end else if (phase != PHASE_INVALID && digit_seen) begin
         shift = int'(suffix) * 10;
         if (shift == 0) begin
            res.byte_size = acc_count;
            res.status = 1'b0;
         end else if ((acc_count >> (64 - shift)) == 0) begin
            res.byte_size = acc_count << shift;
            res.status = 1'b0;
         end
      end
      expected_sizes.push_back(res);
      acc_count = '0;
      digit_seen = 1'b0;
      phase = PHASE_DIGITS;
      suffix = SUFFIX_NONE;
      max_matched = '0;
   endfunction

   // Called at a rising edge; leaves valid high after the transaction
   task automatic send_char(input logic [7:0] ch, input logic last);
      while (!steady && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {ch, last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_parse(ch, last);
      chars_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++) begin
         send_char(text_buf[i], i == text_buf.size() - 1);
      end
      text_buf.delete();
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_sizes.size() != 0) @(posedge clock);
   endtask

   task automatic put_word(input string w);
      for (int i = 0; i < w.len(); i++) text_buf.push_back(w[i]);
   endtask

   task automatic put_decimal(input logic [63:0] v);
      logic [7:0] digs[20];
      int         n = 0;
      do begin
         digs[n] = "0" + 8'(v % 10);
         v = v / 10;
         n++;
      end while (v != 0);
      for (int i = n - 1; i >= 0; i--) text_buf.push_back(digs[i]);
   endtask

   task automatic put_number();
      int unsigned ndig;
      ndig = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 4);
      repeat (ndig) text_buf.push_back("0" + 8'($urandom_range(9)));
   endtask

   task automatic put_suffix();
      string letters = "kKmMgG";
      text_buf.push_back(letters[$urandom_range(5)]);
   endtask

   task automatic put_max(input int unsigned len);
      logic [7:0] letter;
      for (int i = 0; i < len; i++) begin
         letter = MaxWord[8 * (2 - i) +: 8];
         if ($urandom_range(1)) letter = letter - CaseBit;
         text_buf.push_back(letter);
      end
   endtask

   task automatic test_plain_numbers();
      put_word("0");
      send_text();
      put_word("9");
      send_text();
   endtask

   task automatic test_max_word();
      put_word("mAX");
      send_text();
      // a shorter prefix of the word is an ordinary, invalid string
      put_word("ma");
      send_text();
   endtask

   task automatic test_suffixes();
      put_word("1k");
      send_text();
      put_word("2M");
      send_text();
      put_word("3g");
      send_text();
      put_word("5kk");
      send_text();
   endtask

   task automatic test_bad_strings();
      put_word("k");
      send_text();
      put_word("4x");
      send_text();
      text_buf.push_back(8'hff);
      send_text();
      text_buf.push_back(8'h00);
      send_text();
   endtask

   // Hold the result side so the block fills and stalls its input
   task automatic test_backpressure();
      steady = 1'b1;
      hold_left = 150;
      repeat (30) begin
         text_buf.push_back("0" + 8'($urandom_range(9)));
         send_text();
      end
      steady = 1'b0;
      wait_for_results();
   endtask

   task automatic test_random_strings();
      int unsigned kind;
      int unsigned steady_end;
      logic [63:0] base;
      steady_end = chars_sent + SteadyItems;
      while (chars_sent < ItemTarget) begin
         steady = (chars_sent < steady_end);
         kind = $urandom_range(99);
         if (kind < 45) begin
            put_number();
            if ($urandom_range(1)) put_suffix();
         end else if (kind < 55) begin
            case ($urandom_range(3))
               0: put_max(3);
               1: put_max($urandom_range(1, 2));
               2: begin
                  put_max(3);
                  text_buf.push_back(8'($urandom_range(255)));
               end
               default: begin
                  put_number();
                  put_max(3);
               end
            endcase
         end else if (kind < 65) begin
            // straddle the largest count on the last digit
            put_decimal(AllOnes / 10 - 1 + 64'($urandom_range(2)));
            text_buf.push_back("0" + 8'($urandom_range(9)));
         end else if (kind < 75) begin
            // straddle the largest count a suffix can still shift
            base = 64'd1 << (64 - 10 * $urandom_range(1, 3));
            put_decimal(base - 2 + 64'($urandom_range(2)));
            put_suffix();
         end else if (kind < 88) begin
            put_number();
            if ($urandom_range(1)) put_suffix();
            text_buf.push_back(8'($urandom_range(255)));
            if ($urandom_range(1)) put_number();
         end else begin
            repeat ($urandom_range(1, 5)) text_buf.push_back(8'($urandom_range(255)));
         end
         send_text();
      end
      steady = 1'b0;
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 8);
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_sizes.size() == 0) begin
            $error("unexpected result: byte_size %0d status %0b",
                   rsp_data.byte_size, rsp_data.status);
            errors++;
         end else begin
            want = expected_sizes.pop_front();
            if (rsp_data.byte_size !== want.byte_size) begin
               $error("byte_size: expected %0d, got %0d", want.byte_size, rsp_data.byte_size);
               errors++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0b, got %0b", want.status, rsp_data.status);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_plain_numbers();
      test_max_word();
      test_suffixes();
      test_bad_strings();
      test_backpressure();
      test_random_strings();
      wait_for_results();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
